// ----- rtl/bba_pkg.sv -----
// Shared types and constants for the buddy block allocator.
// No dependencies.
package bba_pkg;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAIL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic CFG_INIT_EXP = 1'b0;
    localparam logic CFG_MIN_EXP  = 1'b1;

    localparam int EXP_W       = 6;
    localparam int OFFSET_BITS = 32;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] alloc_size;
        logic [31:0] block_offset;
        logic        cfg_bad;
    } bba_cmd_t;

endpackage

// ----- rtl/bba_front.sv -----
// Front end: accepts transactions, checks configuration, queues commands.
// Depends on bba_pkg.
module bba_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           command,
    input  logic [31:0]          alloc_size,
    input  logic [31:0]          block_offset,
    input  logic [5:0]           init_exp,
    input  logic [5:0]           min_exp,
    input  logic [5:0]           offset_bits,
    output logic                 q_valid,
    input  logic                 q_ready,
    output bba_pkg::bba_cmd_t    q_data
);
    import bba_pkg::*;

    // two-entry queue
    bba_cmd_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    bba_cmd_t   item;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        item.command      = command;
        item.alloc_size   = alloc_size;
        item.block_offset = block_offset;
        item.cfg_bad      = (init_exp > offset_bits) || (min_exp > init_exp);
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/bba_back.sv -----
// Back end: block list memory and the sequencer for init, allocate and free.
// Depends on bba_pkg.
module bba_back #(
    parameter int MAX_BLOCKS  = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  bba_pkg::bba_cmd_t    q_data,
    input  logic [5:0]           init_exp,
    input  logic [5:0]           min_exp,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [bba_pkg::OFFSET_BITS-1:0] granted_offset,
    output logic [1:0]           status
);
    import bba_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = 34; // wide enough for sums up to 2^33

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SUM    = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_SPLIT  = 4'd4;
    localparam logic [3:0] S_SHIFT  = 4'd5;
    localparam logic [3:0] S_MERGE  = 4'd6;
    localparam logic [3:0] S_MRD    = 4'd7;
    localparam logic [3:0] S_REMOVE = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;
    localparam logic [3:0] S_RDWAIT = 4'd10;

    // entry: {used, exponent}
    logic [EXP_W:0] mem [MAX_BLOCKS];
    logic [EXP_W:0] rd_data_reg;
    logic [IW-1:0]  rd_addr;
    logic           we;
    logic [IW-1:0]  wr_addr;
    logic [EXP_W:0] wr_data;

    logic [3:0]     state_reg, state_next;
    logic [3:0]     ret_reg, ret_next;
    bba_cmd_t       cmd_reg, cmd_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [SW-1:0]  off_reg, off_next;
    logic           found_reg, found_next;
    logic [IW-1:0]  best_reg, best_next;
    logic [SW-1:0]  best_off_reg, best_off_next;
    logic [EXP_W-1:0] best_exp_reg, best_exp_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [SW-1:0]  res_off_reg, res_off_next;
    logic [1:0]     res_st_reg, res_st_next;
    logic           ov_reg, ov_next;
    logic [1:0]     phase_reg, phase_next;

    logic [SW-1:0]  rd_size;
    logic [SW-1:0]  req;
    logic [SW-1:0]  half_size;
    logic [EXP_W-1:0] half;

    assign q_ready        = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid      = ov_reg;
    assign granted_offset = res_off_reg[OFFSET_BITS-1:0];
    assign status         = res_st_reg;

    assign rd_size = (rd_data_reg[EXP_W-1:0] > 6'd33) ? '0
                     : (SW'(1) << rd_data_reg[EXP_W-1:0]);
    assign req     = SW'(cmd_reg.alloc_size);
    assign half    = best_exp_reg - 6'd1;
    assign half_size = (half > 6'd33) ? '0 : (SW'(1) << half);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        off_next      = off_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_off_next = best_off_reg;
        best_exp_next = best_exp_reg;
        j_next        = j_reg;
        res_off_next  = res_off_reg;
        res_st_next   = res_st_reg;
        ov_next       = ov_reg;
        phase_next    = phase_reg;
        rd_addr       = i_reg[IW-1:0];
        we            = 1'b0;
        wr_addr       = best_reg;
        wr_data       = '0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    cmd_next     = q_data;
                    res_off_next = '0;
                    res_st_next  = ST_FAIL;
                    i_next       = '0;
                    off_next     = '0;
                    found_next   = 1'b0;
                    if (q_data.cfg_bad)
                    begin
                        state_next = S_DONE;
                    end
                    else if (q_data.command == CMD_INIT)
                    begin
                        we         = 1'b1;
                        wr_addr    = '0;
                        wr_data    = {1'b0, init_exp};
                        count_next = CW'(1);
                        res_st_next = ST_OK;
                        state_next = S_DONE;
                    end
                    else if (q_data.command == CMD_ALLOC || q_data.command == CMD_FREE)
                    begin
                        rd_addr    = '0;
                        ret_next   = S_SUM;
                        state_next = (count_reg == '0) ? S_CHECK : S_RDWAIT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RDWAIT:
            begin
                // read data of entry i_reg valid next cycle
                state_next = ret_reg;
            end
            S_SUM:
            begin
                off_next = off_reg + rd_size;
                if (i_reg + CW'(1) >= count_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_CHECK;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    rd_addr    = IW'(i_reg + CW'(1));
                    state_next = S_RDWAIT;
                end
            end
            S_CHECK:
            begin
                if (init_exp > 6'd33 || off_reg != (SW'(1) << init_exp))
                begin
                    state_next = S_DONE;
                end
                else if (cmd_reg.command == CMD_ALLOC && req == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = '0;
                    off_next   = '0;
                    rd_addr    = '0;
                    ret_next   = S_SCAN;
                    state_next = S_RDWAIT;
                end
            end
            S_SCAN:
            begin
                if (cmd_reg.command == CMD_ALLOC)
                begin
                    if (!rd_data_reg[EXP_W] && rd_size >= req &&
                        (!found_reg || rd_data_reg[EXP_W-1:0] < best_exp_reg))
                    begin
                        found_next    = 1'b1;
                        best_next     = i_reg[IW-1:0];
                        best_exp_next = rd_data_reg[EXP_W-1:0];
                        best_off_next = off_reg;
                    end
                    off_next = off_reg + rd_size;
                    i_next   = i_reg + CW'(1);
                    if (i_reg + CW'(1) >= count_reg)
                    begin
                        state_next = S_SPLIT;
                    end
                    else
                    begin
                        rd_addr    = IW'(i_reg + CW'(1));
                        state_next = S_RDWAIT;
                    end
                end
                else
                begin
                    if (off_reg == SW'(cmd_reg.block_offset))
                    begin
                        best_next     = i_reg[IW-1:0];
                        best_exp_next = rd_data_reg[EXP_W-1:0];
                        best_off_next = off_reg;
                        res_st_next   = ST_OK;
                        state_next    = S_MERGE;
                    end
                    else if (i_reg + CW'(1) >= count_reg)
                    begin
                        res_st_next = ST_NOTFOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        off_next   = off_reg + rd_size;
                        i_next     = i_reg + CW'(1);
                        rd_addr    = IW'(i_reg + CW'(1));
                        state_next = S_RDWAIT;
                    end
                end
            end
            S_SPLIT:
            begin
                // entry best holds {1, best_exp} after each pass
                if (!found_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    we      = 1'b1;
                    wr_addr = best_reg;
                    wr_data = {1'b1, best_exp_reg};
                    if (best_exp_reg == '0 || half_size < req || half < min_exp)
                    begin
                        res_st_next  = ST_OK;
                        res_off_next = best_off_reg;
                        state_next   = S_DONE;
                    end
                    else if (count_reg >= CW'(MAX_BLOCKS))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // shift tail up by one, from the end down to best+1
                        j_next     = count_reg;
                        phase_next = 2'd0;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                // phase 0: issue read of j-1; phase 1: wait; phase 2: write j
                if (j_reg == CW'(best_reg) + CW'(1))
                begin
                    we            = 1'b1;
                    wr_addr       = IW'(j_reg);
                    wr_data       = {1'b0, half};
                    best_exp_next = half;
                    count_next    = count_reg + CW'(1);
                    state_next    = S_SPLIT;
                end
                else
                begin
                    unique case (phase_reg)
                        2'd0:
                        begin
                            rd_addr    = IW'(j_reg - CW'(1));
                            phase_next = 2'd1;
                        end
                        2'd1:
                        begin
                            rd_addr    = IW'(j_reg - CW'(1));
                            phase_next = 2'd2;
                        end
                        default:
                        begin
                            we         = 1'b1;
                            wr_addr    = IW'(j_reg);
                            wr_data    = rd_data_reg;
                            j_next     = j_reg - CW'(1);
                            phase_next = 2'd0;
                        end
                    endcase
                end
            end
            S_MERGE:
            begin
                // mark current block free with its exponent, then look at buddy
                we      = 1'b1;
                wr_addr = best_reg;
                wr_data = {1'b0, best_exp_reg};
                if (best_exp_reg >= init_exp)
                begin
                    state_next = S_DONE;
                end
                else if (best_off_reg[best_exp_reg])
                begin
                    if (best_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = CW'(best_reg) - CW'(1);
                        phase_next = 2'd0;
                        state_next = S_MRD;
                    end
                end
                else
                begin
                    if (CW'(best_reg) + CW'(1) >= count_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = CW'(best_reg) + CW'(1);
                        phase_next = 2'd0;
                        state_next = S_MRD;
                    end
                end
            end
            S_MRD:
            begin
                rd_addr = i_reg[IW-1:0];
                if (phase_reg != 2'd2)
                begin
                    phase_next = phase_reg + 2'd1;
                end
                else if (rd_data_reg[EXP_W] || rd_data_reg[EXP_W-1:0] != best_exp_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // merged block sits at the lower index; remove the upper
                    if (best_off_reg[best_exp_reg])
                    begin
                        best_next    = i_reg[IW-1:0];
                        best_off_next = best_off_reg - (SW'(1) << best_exp_reg);
                        j_next       = CW'(best_reg);
                    end
                    else
                    begin
                        j_next = i_reg;
                    end
                    best_exp_next = best_exp_reg + 6'd1;
                    phase_next    = 2'd0;
                    state_next    = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                // shift entries above j down by one
                if (j_reg + CW'(1) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_MERGE;
                end
                else
                begin
                    unique case (phase_reg)
                        2'd0:
                        begin
                            rd_addr    = IW'(j_reg + CW'(1));
                            phase_next = 2'd1;
                        end
                        2'd1:
                        begin
                            rd_addr    = IW'(j_reg + CW'(1));
                            phase_next = 2'd2;
                        end
                        default:
                        begin
                            we         = 1'b1;
                            wr_addr    = IW'(j_reg);
                            wr_data    = rd_data_reg;
                            j_next     = j_reg + CW'(1);
                            phase_next = 2'd0;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    if (res_st_reg != ST_OK)
                    begin
                        res_off_next = '0;
                    end
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        off_reg      <= off_next;
        best_reg     <= best_next;
        best_off_reg <= best_off_next;
        best_exp_reg <= best_exp_next;
        j_reg        <= j_next;
        res_off_reg  <= res_off_next;
        res_st_reg   <= res_st_next;
        i_reg        <= i_next;
        found_reg    <= found_next;
        phase_reg    <= phase_next;
        ret_reg      <= ret_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ----- rtl/buddy_block_allocator_core.sv -----
// Buddy block allocator, hardware version of the buddy memory scheme.
// Input channel (command, alloc_size, block_offset) and result channel
// (granted_offset, status) use valid/ready; one result per transaction.
// Configuration: cfg_index 0 writes init_exp, 1 writes min_exp; write only
// while idle. A bad config (init_exp above OFFSET_BITS or min_exp above
// init_exp) makes every command answer status 1.
// The front queues up to two commands; the back runs one at a time over a
// block list memory with a registered read port. Init, bad and unknown
// commands go straight to the result; allocate and free make a summing
// pass and a search pass over the block list, plus moving entries for
// each split or merge. One command is in the back at a time.
// Reset clears the block count, the queue and the result valid flag; the
// heap must then be set up with init. When the receiver stalls, the
// result holds and the back does not start its next command; the front
// keeps taking commands until its queue is full.
module buddy_block_allocator_core #(
    parameter int MAX_BLOCKS  = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             command,
    input  logic [bba_pkg::OFFSET_BITS-1:0] alloc_size,
    input  logic [bba_pkg::OFFSET_BITS-1:0] block_offset,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [bba_pkg::OFFSET_BITS-1:0] granted_offset,
    output logic [1:0]             status,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [5:0]             cfg_data
);
    import bba_pkg::*;

    logic [5:0]  init_exp_reg, min_exp_reg;
    logic        q_valid, q_ready;
    bba_cmd_t    q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_exp_reg <= '0;
            min_exp_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_INIT_EXP)
            begin
                init_exp_reg <= cfg_data;
            end
            else
            begin
                min_exp_reg <= cfg_data;
            end
        end
    end

    bba_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .alloc_size   (32'(alloc_size)),
        .block_offset (32'(block_offset)),
        .init_exp     (init_exp_reg),
        .min_exp      (min_exp_reg),
        .offset_bits  (6'(OFFSET_BITS)),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data)
    );

    bba_back #(
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_data         (q_data),
        .init_exp       (init_exp_reg),
        .min_exp        (min_exp_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .granted_offset (granted_offset),
        .status         (status)
    );

endmodule
